// ===== hdl/overlap_tile_address_generator_macros.svh =====
// Assertion macros shared by the checker of the overlap tile address generator.
`ifndef OVERLAP_TILE_ADDRESS_GENERATOR_MACROS_SVH
`define OVERLAP_TILE_ADDRESS_GENERATOR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OTAG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition in one cycle leads to another in the next.
`define OTAG_ASSERT_STEP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/otag_pkg.sv =====
// Package of the overlap tile address generator: widths, limits and register codes.
package otag_pkg;

   localparam int LANE_COUNT  = 7;
   localparam int LANE_W      = 3;
   localparam int DIM_W       = 13;
   localparam int TILE_W      = 9;
   localparam int COUNT_W     = 16;
   localparam int OFFSET_W    = 12;
   localparam int POS_W       = 8;
   localparam int ADDR_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int DIM_MIN  = 1;
   localparam int DIM_MAX  = 4096;
   localparam int TILE_MIN = 3;
   localparam int TILE_MAX = 256;
   localparam int OVERLAP  = 2;

   localparam int RESET_IMAGE_WIDTH  = 64;
   localparam int RESET_IMAGE_HEIGHT = 64;
   localparam int RESET_TILE_COLS    = 32;
   localparam int RESET_TILE_ROWS    = 32;
   localparam int RESET_IMAGE_COUNT  = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_TILE_COLS    = 3'd2,
      CSR_TILE_ROWS    = 3'd3,
      CSR_IMAGE_COUNT  = 3'd4
   } csr_index_type;

endpackage

// ===== hdl/overlap_tile_address_generator.sv =====
// Top level of the overlap tile address generator.
// Each request beat steps the tile walk by one element and, unless the walk is finished, yields
// one response beat with the clamped source pixel index, the lane of the tile, the lane's write
// position and the tile and batch end marks; a beat with restart set clears the walk and all
// lane counts and yields the first element if the image count is not zero, and a beat without
// restart after the end yields nothing. One request beat is taken every cycle: the whole element
// is computed from the walk counters, with a 13 by 13 bit row multiply setting the path, into a
// single response register, so the rate is one element per cycle for as long as the response
// side takes beats. Configuration writes are taken in any cycle and apply from the next element.
module overlap_tile_address_generator import otag_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ADDR_W-1:0]      rsp_src_index,
   output logic [LANE_W-1:0]      rsp_lane,
   output logic [ADDR_W-1:0]      rsp_dst_index,
   output logic                   rsp_tile_end,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration registers
   logic [DIM_W-1:0]   image_width_ff, image_height_ff;
   logic [TILE_W-1:0]  tile_cols_ff, tile_rows_ff;
   logic [COUNT_W-1:0] image_count_ff;

   // walk state
   logic [COUNT_W-1:0]  image_number_ff, image_number_in;
   logic [ADDR_W-1:0]   image_base_ff, image_base_in;
   logic [OFFSET_W-1:0] row_offset_ff, row_offset_in;
   logic [OFFSET_W-1:0] col_offset_ff, col_offset_in;
   logic [POS_W-1:0]    tile_row_ff, tile_row_in;
   logic [POS_W-1:0]    tile_col_ff, tile_col_in;
   logic [LANE_W-1:0]   lane_ff, lane_in;
   logic [ADDR_W-1:0]   lane_count_ff [LANE_COUNT];
   logic [ADDR_W-1:0]   lane_count_in [LANE_COUNT];
   logic                finished_ff, finished_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] src_index_ff, dst_index_ff;
   logic [LANE_W-1:0] rsp_lane_ff;
   logic              tile_end_ff, last_ff;

   // effective dimensions and state for the current beat
   logic [DIM_W-1:0]    w, h;
   logic [TILE_W-1:0]   tc, tr;
   logic [COUNT_W-1:0]  e_image_number;
   logic [ADDR_W-1:0]   e_image_base;
   logic [OFFSET_W-1:0] e_row_offset, e_col_offset;
   logic [POS_W-1:0]    e_tile_row, e_tile_col;
   logic [LANE_W-1:0]   e_lane;
   logic                e_finished;

   logic                 accept, emit;
   logic [DIM_W-1:0]     x_sum, y_sum, x, y;
   logic [2*DIM_W-1:0]   row_prod, image_size;
   logic [ADDR_W-1:0]    src_index, dst_index;
   logic                 col_end, row_end, tile_done;
   logic                 last_tcol, last_trow, last_img, is_last;
   logic [DIM_W-1:0]     col_step, row_step;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DIM_W'(RESET_IMAGE_WIDTH);
         image_height_ff <= DIM_W'(RESET_IMAGE_HEIGHT);
         tile_cols_ff    <= TILE_W'(RESET_TILE_COLS);
         tile_rows_ff    <= TILE_W'(RESET_TILE_ROWS);
         image_count_ff  <= COUNT_W'(RESET_IMAGE_COUNT);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_data[DIM_W-1:0];
            CSR_TILE_COLS:    tile_cols_ff    <= csr_data[TILE_W-1:0];
            CSR_TILE_ROWS:    tile_rows_ff    <= csr_data[TILE_W-1:0];
            CSR_IMAGE_COUNT:  image_count_ff  <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // saturate dimensions into their legal ranges
   always_comb begin
      w  = (image_width_ff == '0) ? DIM_W'(DIM_MIN) :
           (image_width_ff > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : image_width_ff;
      h  = (image_height_ff == '0) ? DIM_W'(DIM_MIN) :
           (image_height_ff > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : image_height_ff;
      tc = (tile_cols_ff < TILE_W'(TILE_MIN)) ? TILE_W'(TILE_MIN) :
           (tile_cols_ff > TILE_W'(TILE_MAX)) ? TILE_W'(TILE_MAX) : tile_cols_ff;
      tr = (tile_rows_ff < TILE_W'(TILE_MIN)) ? TILE_W'(TILE_MIN) :
           (tile_rows_ff > TILE_W'(TILE_MAX)) ? TILE_W'(TILE_MAX) : tile_rows_ff;
   end

   // a restart beat works from a cleared walk
   always_comb begin
      e_image_number = req_restart ? '0 : image_number_ff;
      e_image_base   = req_restart ? '0 : image_base_ff;
      e_row_offset   = req_restart ? '0 : row_offset_ff;
      e_col_offset   = req_restart ? '0 : col_offset_ff;
      e_tile_row     = req_restart ? '0 : tile_row_ff;
      e_tile_col     = req_restart ? '0 : tile_col_ff;
      e_lane         = req_restart ? '0 : lane_ff;
      e_finished     = req_restart ? (image_count_ff == '0) : finished_ff;
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign emit      = accept && !e_finished;

   always_comb begin
      // clamp past the right and bottom edge to replicate it
      x_sum      = DIM_W'(e_col_offset) + DIM_W'(e_tile_col);
      y_sum      = DIM_W'(e_row_offset) + DIM_W'(e_tile_row);
      x          = (x_sum >= w) ? w - DIM_W'(1) : x_sum;
      y          = (y_sum >= h) ? h - DIM_W'(1) : y_sum;
      row_prod   = y * w;
      image_size = w * h;
      src_index  = e_image_base + ADDR_W'(row_prod) + ADDR_W'(x);
      dst_index  = req_restart ? '0 : lane_count_ff[e_lane];

      col_end   = (TILE_W'(e_tile_col) + TILE_W'(1)) >= tc;
      row_end   = (TILE_W'(e_tile_row) + TILE_W'(1)) >= tr;
      tile_done = col_end && row_end;
      last_tcol = (DIM_W'(e_col_offset) + DIM_W'(tc)) >= w;
      last_trow = (DIM_W'(e_row_offset) + DIM_W'(tr)) >= h;
      last_img  = ({1'b0, e_image_number} + (COUNT_W+1)'(1)) >= {1'b0, image_count_ff};
      is_last   = tile_done && last_tcol && last_trow && last_img;

      col_step = DIM_W'(e_col_offset) + DIM_W'(tc) - DIM_W'(OVERLAP);
      row_step = DIM_W'(e_row_offset) + DIM_W'(tr) - DIM_W'(OVERLAP);
   end

   always_comb begin
      image_number_in = image_number_ff;
      image_base_in   = image_base_ff;
      row_offset_in   = row_offset_ff;
      col_offset_in   = col_offset_ff;
      tile_row_in     = tile_row_ff;
      tile_col_in     = tile_col_ff;
      lane_in         = lane_ff;
      finished_in     = finished_ff;
      for (int i = 0; i < LANE_COUNT; i++) begin
         lane_count_in[i] = lane_count_ff[i];
      end
      if (accept) begin
         image_number_in = e_image_number;
         image_base_in   = e_image_base;
         row_offset_in   = e_row_offset;
         col_offset_in   = e_col_offset;
         tile_row_in     = e_tile_row;
         tile_col_in     = e_tile_col;
         lane_in         = e_lane;
         finished_in     = e_finished;
         if (req_restart) begin
            for (int i = 0; i < LANE_COUNT; i++) begin
               lane_count_in[i] = '0;
            end
         end
      end
      if (emit) begin
         lane_count_in[e_lane] = dst_index + ADDR_W'(1);
         // advance innermost first: column, row, tile column, tile row, image
         priority if (is_last) begin
            finished_in = 1'b1;
         end else if (!col_end) begin
            tile_col_in = e_tile_col + POS_W'(1);
         end else begin
            tile_col_in = '0;
            if (!row_end) begin
               tile_row_in = e_tile_row + POS_W'(1);
            end else begin
               tile_row_in = '0;
               lane_in = (e_lane == LANE_W'(LANE_COUNT - 1)) ? '0 : e_lane + LANE_W'(1);
               if (!last_tcol) begin
                  col_offset_in = col_step[OFFSET_W-1:0];
               end else begin
                  col_offset_in = '0;
                  if (!last_trow) begin
                     row_offset_in = row_step[OFFSET_W-1:0];
                  end else begin
                     row_offset_in   = '0;
                     image_base_in   = e_image_base + ADDR_W'(image_size);
                     image_number_in = e_image_number + COUNT_W'(1);
                     lane_in         = '0;
                  end
               end
            end
         end
      end
   end

   // hold the response while the far side stalls; load it when a beat is taken
   assign rsp_valid_in = req_ready ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_number_ff <= '0;
         image_base_ff   <= '0;
         row_offset_ff   <= '0;
         col_offset_ff   <= '0;
         tile_row_ff     <= '0;
         tile_col_ff     <= '0;
         lane_ff         <= '0;
         finished_ff     <= 1'b1;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < LANE_COUNT; i++) begin
            lane_count_ff[i] <= '0;
         end
      end else begin
         image_number_ff <= image_number_in;
         image_base_ff   <= image_base_in;
         row_offset_ff   <= row_offset_in;
         col_offset_ff   <= col_offset_in;
         tile_row_ff     <= tile_row_in;
         tile_col_ff     <= tile_col_in;
         lane_ff         <= lane_in;
         finished_ff     <= finished_in;
         rsp_valid_ff    <= rsp_valid_in;
         for (int i = 0; i < LANE_COUNT; i++) begin
            lane_count_ff[i] <= lane_count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         src_index_ff <= src_index;
         dst_index_ff <= dst_index;
         rsp_lane_ff  <= e_lane;
         tile_end_ff  <= tile_done;
         last_ff      <= is_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_src_index = src_index_ff;
   assign rsp_dst_index = dst_index_ff;
   assign rsp_lane      = rsp_lane_ff;
   assign rsp_tile_end  = tile_end_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== hdl/otag_checker.sv =====
// Port-level checker of the overlap tile address generator, bound to the top level.
`include "overlap_tile_address_generator_macros.svh"
module otag_checker import otag_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_restart,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [ADDR_W-1:0]      rsp_src_index,
   input logic [LANE_W-1:0]      rsp_lane,
   input logic [ADDR_W-1:0]      rsp_dst_index,
   input logic                   rsp_tile_end,
   input logic                   rsp_last
);

   // set after the batch end beat, drop on a restart beat
   logic idle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= 1'b1;
      end else if (req_valid && req_ready && req_restart) begin
         idle_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_last) begin
         idle_ff <= 1'b1;
      end
   end

   `OTAG_ASSERT_STEP(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_src_index) && $stable(rsp_dst_index) && $stable(rsp_lane), "stalled response beat changed")
   `OTAG_ASSERT(a_idle_quiet, idle_ff |-> !rsp_valid, "response beat without a restart after the batch end")
   `OTAG_ASSERT(a_last_ends_tile, rsp_valid && rsp_last |-> rsp_tile_end, "batch end beat not at a tile end")
   `OTAG_ASSERT(a_lane_range, rsp_valid |-> rsp_lane < LANE_W'(LANE_COUNT), "lane out of range")
   `OTAG_ASSERT(a_no_stall_empty, !rsp_valid |-> req_ready, "request stalled with empty response register")

endmodule

bind overlap_tile_address_generator otag_checker u_otag_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench of the overlap tile address generator: random walks checked per beat.
module tb_top;
   import otag_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int ELEMENT_GOAL  = 1350;
   localparam int PHASE_BUDGET  = 250;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AFTER    = 500;
   localparam int IDLE_PERCENT  = 13;

   typedef struct packed {
      logic [ADDR_W-1:0] src_index;
      logic [LANE_W-1:0] lane;
      logic [ADDR_W-1:0] dst_index;
      logic              tile_end;
      logic              last;
   } tile_element_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_restart = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [ADDR_W-1:0]      rsp_src_index;
   logic [LANE_W-1:0]      rsp_lane;
   logic [ADDR_W-1:0]      rsp_dst_index;
   logic                   rsp_tile_end;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   overlap_tile_address_generator DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_src_index (rsp_src_index),
      .rsp_lane      (rsp_lane),
      .rsp_dst_index (rsp_dst_index),
      .rsp_tile_end  (rsp_tile_end),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic               pending_restarts[$];
   tile_element_type   expected_elements[$];
   int                 elements_predicted = 0;
   int                 failures = 0;
   int                 cycle_count = 0;
   logic               steady = 1'b0;
   int                 hold_left = 0;
   logic               held_off = 1'b0;

   // Settings as the walk sees them.
   logic [DIM_W-1:0]   cfg_width  = DIM_W'(RESET_IMAGE_WIDTH);
   logic [DIM_W-1:0]   cfg_height = DIM_W'(RESET_IMAGE_HEIGHT);
   logic [TILE_W-1:0]  cfg_tcols  = TILE_W'(RESET_TILE_COLS);
   logic [TILE_W-1:0]  cfg_trows  = TILE_W'(RESET_TILE_ROWS);
   logic [COUNT_W-1:0] cfg_images = COUNT_W'(RESET_IMAGE_COUNT);

   // Walk position.
   logic [COUNT_W-1:0]  img_num = '0;
   logic [ADDR_W-1:0]   img_base = '0;
   logic [OFFSET_W-1:0] row_off = '0;
   logic [OFFSET_W-1:0] col_off = '0;
   logic [POS_W-1:0]    row_pos = '0;
   logic [POS_W-1:0]    col_pos = '0;
   logic [LANE_W-1:0]   cur_lane = '0;
   logic [ADDR_W-1:0]   lane_writes [LANE_COUNT];
   logic                walk_finished = 1'b1;

   initial begin
      for (int i = 0; i < LANE_COUNT; i++) lane_writes[i] = '0;
   end

   function automatic logic [ADDR_W-1:0] clip(input logic [ADDR_W-1:0] v, input int lo,
                                              input int hi);
      if (v < ADDR_W'(lo)) return ADDR_W'(lo);
      if (v > ADDR_W'(hi)) return ADDR_W'(hi);
      return v;
   endfunction

   // Step the walk by one accepted request beat and queue the element it yields.
   task automatic step_walk(input logic restart);
      logic [ADDR_W-1:0] w, h, tc, tr, x, y, col, row, c_off, r_off, n_img, n_total;
      logic [LANE_W-1:0] ln;
      logic              col_end, row_end, last_tcol, last_trow, last_image;
      tile_element_type  elem;
      w  = clip(ADDR_W'(cfg_width), DIM_MIN, DIM_MAX);
      h  = clip(ADDR_W'(cfg_height), DIM_MIN, DIM_MAX);
      tc = clip(ADDR_W'(cfg_tcols), TILE_MIN, TILE_MAX);
      tr = clip(ADDR_W'(cfg_trows), TILE_MIN, TILE_MAX);
      if (restart) begin
         img_num  = '0;
         img_base = '0;
         row_off  = '0;
         col_off  = '0;
         row_pos  = '0;
         col_pos  = '0;
         cur_lane = '0;
         for (int i = 0; i < LANE_COUNT; i++) lane_writes[i] = '0;
         walk_finished = (cfg_images == '0);
      end
      if (walk_finished) return;

      col     = ADDR_W'(col_pos);
      row     = ADDR_W'(row_pos);
      c_off   = ADDR_W'(col_off);
      r_off   = ADDR_W'(row_off);
      n_img   = ADDR_W'(img_num);
      n_total = ADDR_W'(cfg_images);
      // Clamp past the right and bottom edges to replicate the last column and row.
      x = c_off + col;
      if (x >= w) x = w - 1;
      y = r_off + row;
      if (y >= h) y = h - 1;
      ln         = cur_lane;
      col_end    = (col + 1 >= tc);
      row_end    = (row + 1 >= tr);
      last_tcol  = (c_off + tc >= w);
      last_trow  = (r_off + tr >= h);
      last_image = (n_img + 1 >= n_total);

      elem.src_index = img_base + y * w + x;
      elem.lane      = ln;
      elem.dst_index = lane_writes[ln];
      elem.tile_end  = col_end && row_end;
      elem.last      = col_end && row_end && last_tcol && last_trow && last_image;
      expected_elements.push_back(elem);
      elements_predicted++;
      lane_writes[ln] = lane_writes[ln] + 1;

      if (elem.last) begin
         walk_finished = 1'b1;
      end else if (!col_end) begin
         col_pos = col_pos + POS_W'(1);
      end else begin
         col_pos = '0;
         if (!row_end) begin
            row_pos = row_pos + POS_W'(1);
         end else begin
            row_pos  = '0;
            cur_lane = (ln == LANE_W'(LANE_COUNT - 1)) ? '0 : ln + LANE_W'(1);
            if (!last_tcol) begin
               col_off = OFFSET_W'(c_off + tc - OVERLAP);
            end else begin
               col_off = '0;
               if (!last_trow) begin
                  row_off = OFFSET_W'(r_off + tr - OVERLAP);
               end else begin
                  row_off  = '0;
                  img_base = img_base + w * h;
                  img_num  = img_num + COUNT_W'(1);
                  cur_lane = '0;
               end
            end
         end
      end
   endtask

   // Request driver: keep valid and payload steady until the beat is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) step_walk(req_restart);
         if (!req_valid || req_ready) begin
            if (pending_restarts.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_valid   <= 1'b1;
               req_restart <= pending_restarts.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side: random stalls plus one long hold-off to back up the block.
   always @(posedge clock) begin
      if (!held_off && elements_predicted >= HOLD_AFTER) begin
         hold_left = HOLD_CYCLES;
         held_off  = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                                input logic [ADDR_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : result_monitor
      tile_element_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_elements.size() == 0) begin
            $display("%0t: src_index expected none actual %h", $time, rsp_src_index);
            failures++;
         end else begin
            want = expected_elements.pop_front();
            compare_field("src_index", want.src_index, rsp_src_index);
            compare_field("lane", ADDR_W'(want.lane), ADDR_W'(rsp_lane));
            compare_field("dst_index", want.dst_index, rsp_dst_index);
            compare_field("tile_end", ADDR_W'(want.tile_end), ADDR_W'(rsp_tile_end));
            compare_field("last", ADDR_W'(want.last), ADDR_W'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Call at a rising edge; returns at the edge where the write was taken.
   task automatic write_setting(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width  = value[DIM_W-1:0];
         CSR_IMAGE_HEIGHT: cfg_height = value[DIM_W-1:0];
         CSR_TILE_COLS:    cfg_tcols  = value[TILE_W-1:0];
         CSR_TILE_ROWS:    cfg_trows  = value[TILE_W-1:0];
         CSR_IMAGE_COUNT:  cfg_images = value[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input int w, input int h, input int tc, input int tr,
                                input int n, input logic [4:0] which);
      if (which[0]) write_setting(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      if (which[1]) write_setting(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      if (which[2]) write_setting(CSR_TILE_COLS, CSR_DATA_W'(tc));
      if (which[3]) write_setting(CSR_TILE_ROWS, CSR_DATA_W'(tr));
      if (which[4]) write_setting(CSR_IMAGE_COUNT, CSR_DATA_W'(n));
      csr_valid <= 1'b0;
   endtask

   task automatic queue_items(input logic with_restart, input int advances);
      if (with_restart) pending_restarts.push_back(1'b1);
      repeat (advances) pending_restarts.push_back(1'b0);
   endtask

   // Wait until every beat is sent and answered, then let the response register settle.
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_restarts.size() != 0 || req_valid || expected_elements.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      int phase_no, budget, w, h, tc, tr, n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Advance while idle, then restart at the reset settings and restart mid-walk.
      queue_items(1'b0, 1);
      queue_items(1'b1, 3);
      queue_items(1'b1, 1);
      wait_quiet();
      // One-pixel image: every element clamps onto the same pixel, walk ends, then idles.
      load_settings(1, 1, TILE_MIN, TILE_MIN, 1, 5'b11111);
      queue_items(1'b1, 9);
      wait_quiet();
      load_settings(DIM_MAX, DIM_MAX, TILE_MAX, TILE_MAX, 16'hFFFF, 5'b11111);
      queue_items(1'b1, 1);
      wait_quiet();
      // Out-of-range sizes saturate; an empty batch yields nothing.
      load_settings(0, 16'hFFFF, TILE_MIN - 1, 16'hFFFF, 0, 5'b11111);
      queue_items(1'b1, 1);
      wait_quiet();
      load_settings(0, 0, 0, 0, 2, 5'b10000);
      queue_items(1'b1, 2);
      wait_quiet();

      phase_no = 0;
      while (elements_predicted < ELEMENT_GOAL) begin
         steady = (phase_no % 4 == 1);
         tc = $urandom_range(TILE_MIN, 8);
         tr = $urandom_range(TILE_MIN, 8);
         w  = $urandom_range(DIM_MIN, 2 * tc);
         h  = $urandom_range(DIM_MIN, 2 * tr);
         n  = $urandom_range(1, 3);
         if ($urandom_range(5) == 0) begin
            case ($urandom_range(4))
               0: w = $urandom_range(0, 16'hFFFF);
               1: h = $urandom_range(0, 16'hFFFF);
               2: tc = $urandom_range(0, 16'hFFFF);
               3: tr = $urandom_range(0, 16'hFFFF);
               default: n = ($urandom_range(1) == 0) ? 0 : 16'hFFFF;
            endcase
         end
         load_settings(w, h, tc, tr, n, 5'($urandom_range(1, 31)));
         // Mostly restart; otherwise carry on with the walk under the new settings.
         budget = elements_predicted + PHASE_BUDGET;
         if ($urandom_range(3) != 0) pending_restarts.push_back(1'b1);
         do begin
            @(negedge clock);
            if (!walk_finished && elements_predicted < budget && pending_restarts.size() < 4)
               repeat (8) pending_restarts.push_back($urandom_range(49) == 0);
         end while (pending_restarts.size() != 0 ||
                    (!walk_finished && elements_predicted < budget));
         repeat ($urandom_range(3)) pending_restarts.push_back(1'b0);
         wait_quiet();
         phase_no++;
      end

      repeat (10) @(posedge clock);
      if (failures == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/otag_pkg.sv
hdl/overlap_tile_address_generator.sv
hdl/otag_checker.sv
test/tb_top.sv
